[rtl/hex_record_halfword_parser_macros.svh]
// assertion macros for the hex record halfword parser
// included by the top level; expects clk and rst_n in scope
`ifndef HEX_RECORD_HALFWORD_PARSER_MACROS_SVH
`define HEX_RECORD_HALFWORD_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define HRHP_ASSERT_NOW(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HRHP_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

[rtl/hrhp_pkg.sv]
// shared types, constants and the hex digit decoder of the hex record parser
// no dependencies
`timescale 1ns / 1ps

package hrhp_pkg;

  // ascii codes used by the digit decoder
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
  localparam logic [7:0] CHAR_A_OFFSET = 8'd55;

  // config register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        CFG_IDX_FLASH_BASE = 1'b0;
  localparam logic [31:0] FLASH_BASE_RESET   = 32'h0800_0000;

  // what the front end found a character to be
  typedef enum logic [3:0] {
    TK_START,
    TK_COUNT,
    TK_ADDR_FIRST,
    TK_ADDR,
    TK_ADDR_LAST,
    TK_SKIP,
    TK_DATA_FIRST,
    TK_DATA,
    TK_DATA_LAST
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [3:0]  digit;
  } token_t;

  // '0'..'9' and 'A'..'F' to their value, anything else to zero
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      t = c - CHAR_A_OFFSET;
    end
    return t[3:0];
  endfunction

endpackage

[rtl/hrhp_front.sv]
// front end: tracks the character position and classifies each character
// depends on hrhp_pkg
`timescale 1ns / 1ps

module hrhp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc_i,
  input  logic [7:0]      char_i,
  input  logic            start_i,
  output hrhp_pkg::token_t tok_o
);

  localparam logic [3:0] POS_MARK       = 4'd0;
  localparam logic [3:0] POS_COUNT_LAST = 4'd2;
  localparam logic [3:0] POS_ADDR_FIRST = 4'd3;
  localparam logic [3:0] POS_ADDR_LAST  = 4'd6;
  localparam logic [3:0] POS_TYPE_LAST  = 4'd8;
  localparam logic [3:0] POS_DATA_FIRST = 4'd9;
  localparam logic [3:0] POS_DATA_LAST  = 4'd12;

  logic [3:0] pos_r;
  logic [3:0] pos_nxt;
  hrhp_pkg::tok_kind_t kind;

  // classify by position and work out the next position
  always_comb begin
    pos_nxt = pos_r + 4'd1;
    if (start_i || pos_r == POS_MARK) begin
      kind    = hrhp_pkg::TK_START;
      pos_nxt = 4'd1;
    end else if (pos_r <= POS_COUNT_LAST) begin
      kind = hrhp_pkg::TK_COUNT;
    end else if (pos_r == POS_ADDR_FIRST) begin
      kind = hrhp_pkg::TK_ADDR_FIRST;
    end else if (pos_r < POS_ADDR_LAST) begin
      kind = hrhp_pkg::TK_ADDR;
    end else if (pos_r == POS_ADDR_LAST) begin
      kind = hrhp_pkg::TK_ADDR_LAST;
    end else if (pos_r <= POS_TYPE_LAST) begin
      kind = hrhp_pkg::TK_SKIP;
    end else if (pos_r == POS_DATA_FIRST) begin
      kind = hrhp_pkg::TK_DATA_FIRST;
    end else if (pos_r < POS_DATA_LAST) begin
      kind = hrhp_pkg::TK_DATA;
    end else begin
      kind    = hrhp_pkg::TK_DATA_LAST;
      pos_nxt = POS_DATA_FIRST;
    end
  end

  assign tok_o.kind  = kind;
  assign tok_o.digit = hrhp_pkg::hex_digit(char_i);

  // position register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_MARK;
    end else if (acc_i) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[rtl/hrhp_queue.sv]
// small token queue between the front end and the back end
// depends on hrhp_pkg
`timescale 1ns / 1ps

module hrhp_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  hrhp_pkg::token_t push_tok_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output hrhp_pkg::token_t tok_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hrhp_pkg::token_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign valid_o = (cnt_r != '0);
  assign tok_o   = slot_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // token storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tok_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/hrhp_back.sv]
// back end: builds count, address and halfwords from tokens, holds the result register
// depends on hrhp_pkg
`timescale 1ns / 1ps

module hrhp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      flash_base_i,
  input  logic             tok_valid_i,
  input  hrhp_pkg::token_t tok_i,
  output logic             tok_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      out_addr_o,
  output logic [15:0]      out_hw_o,
  output logic             out_last_o
);

  logic [7:0]  bc_r,  bc_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [31:0] na_r,  na_nxt;
  logic [6:0]  wd_r,  wd_nxt;
  logic        out_valid_r;
  logic [31:0] out_addr_r;
  logic [15:0] out_hw_r;
  logic        out_last_r;
  logic        emit;
  logic        done;
  logic [6:0]  total;
  logic [15:0] acc_shift;

  assign tok_pop_o = tok_valid_i && (!out_valid_r || out_ready_i);
  assign total     = bc_r[7:1];
  assign done      = (wd_r >= total);
  assign acc_shift = {acc_r[11:0], tok_i.digit};

  // state update for one token
  always_comb begin
    bc_nxt  = bc_r;
    acc_nxt = acc_r;
    na_nxt  = na_r;
    wd_nxt  = wd_r;
    emit    = 1'b0;
    case (tok_i.kind)
      hrhp_pkg::TK_START: begin
        bc_nxt  = '0;
        acc_nxt = '0;
        na_nxt  = '0;
        wd_nxt  = '0;
      end
      hrhp_pkg::TK_COUNT: begin
        bc_nxt = {bc_r[3:0], tok_i.digit};
      end
      hrhp_pkg::TK_ADDR_FIRST: begin
        acc_nxt = {12'h000, tok_i.digit};
      end
      hrhp_pkg::TK_ADDR: begin
        acc_nxt = acc_shift;
      end
      hrhp_pkg::TK_ADDR_LAST: begin
        acc_nxt = acc_shift;
        na_nxt  = flash_base_i | {16'h0000, acc_shift};
      end
      hrhp_pkg::TK_SKIP: begin
        acc_nxt = acc_r;
      end
      hrhp_pkg::TK_DATA_FIRST: begin
        if (!done) acc_nxt = {12'h000, tok_i.digit};
      end
      hrhp_pkg::TK_DATA: begin
        if (!done) acc_nxt = acc_shift;
      end
      hrhp_pkg::TK_DATA_LAST: begin
        if (!done) begin
          acc_nxt = acc_shift;
          na_nxt  = na_r + 32'd2;
          wd_nxt  = wd_r + 7'd1;
          emit    = 1'b1;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // record state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r  <= '0;
      acc_r <= '0;
      na_r  <= '0;
      wd_r  <= '0;
    end else if (tok_pop_o) begin
      bc_r  <= bc_nxt;
      acc_r <= acc_nxt;
      na_r  <= na_nxt;
      wd_r  <= wd_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tok_pop_o && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (tok_pop_o && emit) begin
      out_addr_r <= na_r;
      out_hw_r   <= acc_shift;
      out_last_r <= ({1'b0, wd_r} + 8'd1 == {1'b0, total});
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_addr_o  = out_addr_r;
  assign out_hw_o    = out_hw_r;
  assign out_last_o  = out_last_r;

endmodule

[rtl/hex_record_halfword_parser.sv]
// Hex record halfword parser. Takes one ASCII character of a hex record per
// cycle on the in_ stream (in_tuser high marks the record's start mark) and
// returns each group of four data digits as a halfword with its flash byte
// address (flash_base OR record address, rising by 2) on the out_ stream,
// tlast set on the last halfword of the record. One character is accepted
// every cycle while results drain; out_tvalid for a halfword rises once its
// last digit has passed through the token queue and then the result register.
// A stalled result register holds the back end, and once the queue is full
// in_tready drops.
// flash_base sits at byte address 0 of the config port and may be changed
// only while the block is idle.
// depends on hrhp_pkg, hrhp_front, hrhp_queue, hrhp_back and the macros header
`timescale 1ns / 1ps
`include "hex_record_halfword_parser_macros.svh"

module hex_record_halfword_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic [0:0]  in_tuser,   // [0] record_start
  // halfword stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] write_address, [47:32] halfword
  output logic        out_tlast,  // last_of_record
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [hrhp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             in_acc;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  hrhp_pkg::token_t front_tok;
  hrhp_pkg::token_t q_tok;
  logic [31:0]      flash_base_r;
  logic [31:0]      out_addr;
  logic [15:0]      out_hw;
  logic             cfg_wr;
  logic             cfg_hit;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == hrhp_pkg::CFG_IDX_FLASH_BASE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? flash_base_r : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r <= hrhp_pkg::FLASH_BASE_RESET;
    end else if (cfg_wr && cfg_hit) begin
      flash_base_r <= cfg_pwdata;
    end
  end

  // classify characters
  hrhp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (in_acc),
    .char_i  (in_tdata),
    .start_i (in_tuser[0]),
    .tok_o   (front_tok)
  );

  // token queue
  hrhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (in_acc),
    .push_tok_i (front_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .tok_o      (q_tok)
  );

  // assemble halfwords
  hrhp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .flash_base_i (flash_base_r),
    .tok_valid_i  (q_valid),
    .tok_i        (q_tok),
    .tok_pop_o    (q_pop),
    .out_valid_o  (out_tvalid),
    .out_ready_i  (out_tready),
    .out_addr_o   (out_addr),
    .out_hw_o     (out_hw),
    .out_last_o   (out_tlast)
  );

  assign out_tdata = {out_hw, out_addr};

  // checks
  `HRHP_ASSERT_NOW(a_full_not_empty, !in_tready, q_valid, "queue full but empty")
  `HRHP_ASSERT_NEXT(a_push_lands, in_tvalid && in_tready, q_valid, "accepted request lost")
  `HRHP_ASSERT_NOW(a_no_pop_on_stall, q_pop, !(out_tvalid && !out_tready), "pop while result stalled")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for the hex record halfword parser: directed and random
// hex records go in, every halfword is checked against a behavioral predictor
// depends on hrhp_pkg and hex_record_halfword_parser

module tb_top;

  localparam int unsigned IDLE_PCT      = 27;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [hrhp_pkg::CFG_ADDR_W-1:0] FLASH_BASE_ADDR =
    hrhp_pkg::CFG_ADDR_W'(4 * hrhp_pkg::CFG_IDX_FLASH_BASE);

  // character positions within a record
  localparam logic [8:0] COUNT_LAST_POS = 9'd2;
  localparam logic [8:0] ADDR_FIRST_POS = 9'd3;
  localparam logic [8:0] ADDR_LAST_POS  = 9'd6;
  localparam logic [8:0] DATA_FIRST_POS = 9'd9;
  localparam logic [8:0] DATA_LAST_POS  = 9'd12;

  localparam logic [7:0] START_MARK = 8'h3A;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_F    = 8'h66;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] halfword;
    logic        last;
  } flash_write_t;

  // predicts flash writes from the character stream and checks the results
  class halfword_scoreboard;
    logic [31:0]  flash_base;
    logic [8:0]   position;
    logic [7:0]   byte_count;
    logic [15:0]  digits;
    logic [31:0]  next_address;
    logic [6:0]   words_done;
    flash_write_t expected_writes[$];
    int           errors;
    int           checked;

    function new();
      flash_base = hrhp_pkg::FLASH_BASE_RESET;
      clear_record();
      position = '0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void clear_record();
      byte_count   = '0;
      digits       = '0;
      next_address = '0;
      words_done   = '0;
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      return 4'h0;
    endfunction

    function void note_char(logic [7:0] c, logic start);
      logic [3:0]   d;
      logic [6:0]   total;
      flash_write_t w;
      d = digit_value(c);
      total = byte_count[7:1];
      // start mark, or first character after reset
      if (start || position == '0) begin
        clear_record();
        position = 9'd1;
        return;
      end
      if (position <= COUNT_LAST_POS) begin
        byte_count = {byte_count[3:0], d};
        position++;
        return;
      end
      if (position <= ADDR_LAST_POS) begin
        digits = (position == ADDR_FIRST_POS) ? {12'h000, d} : {digits[11:0], d};
        if (position == ADDR_LAST_POS) next_address = flash_base | {16'h0000, digits};
        position++;
        return;
      end
      // record type digits
      if (position < DATA_FIRST_POS) begin
        position++;
        return;
      end
      // record already complete
      if (words_done >= total) return;
      digits = (position == DATA_FIRST_POS) ? {12'h000, d} : {digits[11:0], d};
      if (position < DATA_LAST_POS) begin
        position++;
        return;
      end
      w.address  = next_address;
      w.halfword = digits;
      w.last     = (words_done + 7'd1 == total);
      expected_writes.push_back(w);
      next_address += 32'd2;
      words_done++;
      position = DATA_FIRST_POS;
    endfunction

    function void check_write(flash_write_t got);
      flash_write_t want;
      checked++;
      if (expected_writes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected halfword %h at %h last %0b",
                   got.halfword, got.address, got.last);
        return;
      end
      want = expected_writes.pop_front();
      if (got.address !== want.address || got.halfword !== want.halfword ||
          got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: write %0d expected addr %h data %h last %0b, %s %h %s %h %s %0b",
                   checked, want.address, want.halfword, want.last,
                   "got addr", got.address, "data", got.halfword, "last", got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] character
  logic [0:0]  in_tuser;   // [0] record_start
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] write_address, [47:32] halfword
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [hrhp_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  halfword_scoreboard sb;
  bit calm;
  bit hold_request;
  int chars_sent;
  int records_sent;
  int settings;
  int quiet_cycles;

  hex_record_halfword_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    string digit_chars;
    digit_chars = "0123456789ABCDEF";
    return digit_chars[v];
  endfunction

  // mostly valid digits, some lower case and some arbitrary bytes
  function automatic logic [7:0] data_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return hex_char(4'($urandom));
    if (r < 92) return 8'($urandom_range(LOWER_A, LOWER_F));
    return 8'($urandom);
  endfunction

  // one character request, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c, input logic start);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(c, start);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic first_start);
    for (int i = 0; i < s.len(); i++) send_char(s[i], first_start && i == 0);
  endtask

  // builds one record; unless clean, it may carry noise or be cut short
  task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                             input bit clean);
    logic [7:0] rec[$];
    int cut;
    rec.push_back((clean || $urandom_range(0, 9) != 0) ? START_MARK : 8'($urandom));
    rec.push_back(hex_char(count[7:4]));
    rec.push_back(hex_char(count[3:0]));
    if (!clean && $urandom_range(0, 49) == 0) rec[1] = 8'($urandom);
    for (int i = 3; i >= 0; i--) rec.push_back(hex_char(addr[4*i +: 4]));
    rec.push_back("0");
    rec.push_back(clean ? "0" : hex_char(4'($urandom)));
    repeat (2 * count) rec.push_back(clean ? hex_char(4'($urandom)) : data_char());
    rec.push_back(hex_char(4'($urandom)));
    rec.push_back(hex_char(4'($urandom)));
    if (!clean) begin
      repeat ($urandom_range(0, 2)) rec.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, rec.size() - 1);
        while (rec.size() > cut) void'(rec.pop_back());
      end
    end
    foreach (rec[i]) send_char(rec[i], i == 0);
    records_sent++;
  endtask

  task automatic send_random_records(input int n_chars);
    int first;
    int r;
    first = chars_sent;
    while (chars_sent - first < n_chars) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom), 1'($urandom_range(0, 3) == 0));
      end else begin
        send_record((r < 8) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(0, 12)),
                    16'($urandom), 1'b0);
      end
    end
  endtask

  // stop offering and let every predicted halfword come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_flash_base(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FLASH_BASE_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.flash_base = value;
    settings++;
  endtask

  // result side: check each halfword request, then pick next ready
  initial begin : result_sink
    flash_write_t got;
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.address  = out_tdata[31:0];
        got.halfword = out_tdata[47:32];
        got.last     = out_tlast;
        sb.check_write(got);
      end
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d halfwords pending",
               quiet_cycles, sb.expected_writes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first character has no start mark; second halfword cut off by a start mark
    send_text("Q04FFFF0089AF", 1'b0);
    // count of one gives nothing
    send_text(":0100000012", 1'b1);
    // lower case and non-digit bytes decode as zero, extra chars after the end
    send_text(":02000000c", 1'b1);
    send_char(8'hFF, 1'b0);
    send_text("E", 1'b0);
    send_char(8'h00, 1'b0);
    send_text("7", 1'b0);
    wait_idle();

    // zero base, no idling at all
    write_flash_base(32'h0000_0000);
    calm = 1'b1;
    send_random_records(80);
    wait_idle();
    calm = 1'b0;

    // all-ones base, long output stall while input keeps coming
    write_flash_base(32'hFFFF_FFFF);
    hold_request = 1'b1;
    send_random_records(80);
    wait_idle();

    // long record, address wrapping past the top
    write_flash_base(32'hFFFF_0000);
    send_record(8'h40, 16'hFFF0, 1'b1);
    wait_idle();

    write_flash_base($urandom);
    send_random_records(80);
    wait_idle();

    write_flash_base(hrhp_pkg::FLASH_BASE_RESET);
    send_random_records(60);
    wait_idle();

    $display("run sent %0d characters in %0d generated records over %0d base settings",
             chars_sent, records_sent, settings);
    $display("%0d halfwords checked, incl. a 64-byte record wrapping the address %s",
             sb.checked, "and a long output stall");
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
